// ===== sv/pcc_pkg.sv =====
// Shared types, codes and helpers for the pileup consensus contig caller.
// No dependencies; every other file imports this package.
package pcc_pkg;

	localparam int unsigned CountW  = 8;
	localparam int unsigned DepthW  = 11;
	localparam int unsigned WordW   = 32;
	localparam int unsigned InsColW = 2;
	localparam int unsigned Symbols    = 5;
	localparam int unsigned InsSymbols = 4;

	// func codes
	localparam logic [1:0] FUNC_LOCUS  = 2'd0;
	localparam logic [1:0] FUNC_INSERT = 2'd1;
	localparam logic [1:0] FUNC_END    = 2'd2;
	localparam logic [1:0] FUNC_RSVD   = 2'd3;

	// result kinds
	localparam logic KIND_BASE  = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	// symbol codes, order A C G T gap
	localparam logic [2:0] SYM_A   = 3'd0;
	localparam logic [2:0] SYM_C   = 3'd1;
	localparam logic [2:0] SYM_G   = 3'd2;
	localparam logic [2:0] SYM_T   = 3'd3;
	localparam logic [2:0] SYM_GAP = 3'd4;

	// configuration register indexes
	localparam logic REG_MIN_DEPTH  = 1'b0;
	localparam logic REG_MIN_LENGTH = 1'b1;

	typedef struct packed {
		logic [1:0]        func;
		logic [CountW-1:0] count_a;
		logic [CountW-1:0] count_c;
		logic [CountW-1:0] count_g;
		logic [CountW-1:0] count_t;
		logic [CountW-1:0] count_gap;
		logic              covered;
		logic              has_insertion;
	} item_t;

	typedef struct packed {
		logic             kind;
		logic [1:0]       base;
		logic [WordW-1:0] contig_number;
		logic [WordW-1:0] start_locus;
		logic [WordW-1:0] end_locus;
		logic [WordW-1:0] contig_length;
		logic             keep;
	} result_t;

	// majority vote of one item, locus and insertion views
	typedef struct packed {
		logic [CountW-1:0] loc_best;
		logic [2:0]        loc_win;
		logic [DepthW-1:0] depth;
		logic [CountW-1:0] ins_best;
		logic [1:0]        ins_win;
	} vote_t;

	function automatic logic [WordW-1:0] sat_inc(input logic [WordW-1:0] v);
		return (v == '1) ? v : v + WordW'(1);
	endfunction

endpackage

// ===== sv/pcc_vote.sv =====
// Majority vote over the five pileup counts of one item, plus depth.
// Depth sums them if covered. Depends on pcc_pkg. Purely combinational.
module pcc_vote
	import pcc_pkg::*;
(
	input  item_t item,
	output vote_t vote
);

	logic [CountW-1:0] cnt [Symbols];
	logic [CountW-1:0] best [Symbols];
	logic [2:0]        win  [Symbols];

	assign cnt[0] = item.count_a;
	assign cnt[1] = item.count_c;
	assign cnt[2] = item.count_g;
	assign cnt[3] = item.count_t;
	assign cnt[4] = item.count_gap;

	// strict greater-than chain: earliest symbol keeps ties
	always_comb begin
		best[0] = cnt[0];
		win[0]  = SYM_A;
		for (int i = 1; i < Symbols; i++) begin
			if (cnt[i] > best[i-1]) begin
				best[i] = cnt[i];
				win[i]  = 3'(i);
			end else begin
				best[i] = best[i-1];
				win[i]  = win[i-1];
			end
		end
	end

	always_comb begin
		vote.ins_best = best[InsSymbols-1];
		vote.ins_win  = win[InsSymbols-1][1:0];
		if (item.covered) begin
			vote.loc_best = best[Symbols-1];
			vote.loc_win  = win[Symbols-1];
			vote.depth    = DepthW'(item.count_a) + DepthW'(item.count_c)
				+ DepthW'(item.count_g) + DepthW'(item.count_t)
				+ DepthW'(item.count_gap);
		end else begin
			// nothing aligned: count zero, A wins, depth is count_a
			vote.loc_best = '0;
			vote.loc_win  = SYM_A;
			vote.depth    = DepthW'(item.count_a);
		end
	end

endmodule

// ===== sv/pcc_track.sv =====
// Contig tracking state, result formation and the result register.
// Depends on pcc_pkg; takes the vote of pcc_vote for the item in stage 1.
module pcc_track
	import pcc_pkg::*;
#(
	parameter int unsigned INS_COLS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  item_t             item_s1,
	input  vote_t             vote,
	input  logic [CountW-1:0] min_depth,
	input  logic [WordW-1:0]  min_length,
	input  logic              result_ready,
	output logic              result_valid,
	output result_t           result
);

	logic [WordW-1:0]   locus_pos_q, contig_start_q, contig_bases_q, kept_q;
	logic [DepthW-1:0]  locus_depth_q;
	logic               ins_open_q;
	logic [InsColW-1:0] ins_col_q;

	logic [WordW-1:0]   locus_pos_d, contig_start_d, contig_bases_d, kept_d;
	logic [DepthW-1:0]  locus_depth_d;
	logic               ins_open_d;
	logic [InsColW-1:0] ins_col_d;
	logic [InsColW-1:0] ins_col_inc;

	logic               emit;
	result_t            res_d;
	logic               result_valid_q;
	result_t            result_q;
	logic               keep_now;
	logic [WordW-1:0]   close_end;

	assign keep_now    = contig_bases_q >= min_length;
	assign ins_col_inc = ins_col_q + InsColW'(1);

	always_comb begin
		locus_pos_d    = locus_pos_q;
		contig_start_d = contig_start_q;
		contig_bases_d = contig_bases_q;
		kept_d         = kept_q;
		locus_depth_d  = locus_depth_q;
		ins_open_d     = ins_open_q;
		ins_col_d      = ins_col_q;
		emit           = 1'b0;
		close_end      = locus_pos_q;
		res_d          = '0;

		unique case (item_s1.func)
			FUNC_LOCUS: begin
				ins_open_d  = 1'b0;
				ins_col_d   = '0;
				locus_pos_d = sat_inc(locus_pos_q);
				if (vote.loc_best >= min_depth) begin
					if (vote.loc_win != SYM_GAP) begin
						emit           = 1'b1;
						res_d.kind     = KIND_BASE;
						res_d.base     = vote.loc_win[1:0];
						contig_bases_d = sat_inc(contig_bases_q);
						locus_depth_d  = vote.depth;
						ins_open_d     = item_s1.has_insertion;
					end
				end else begin
					emit           = 1'b1;
					close_end      = locus_pos_q;
					contig_start_d = sat_inc(locus_pos_q);
					contig_bases_d = '0;
					if (keep_now) kept_d = sat_inc(kept_q);
				end
			end
			FUNC_INSERT: begin
				if (ins_open_q && ins_col_q < InsColW'(INS_COLS)) begin
					if ({2'b00, vote.ins_best} > locus_depth_q[DepthW-1:1]) begin
						emit           = 1'b1;
						res_d.kind     = KIND_BASE;
						res_d.base     = vote.ins_win;
						contig_bases_d = sat_inc(contig_bases_q);
						ins_col_d      = ins_col_inc;
						if (ins_col_inc >= InsColW'(INS_COLS)) ins_open_d = 1'b0;
					end else begin
						ins_open_d = 1'b0;
					end
				end
			end
			FUNC_END: begin
				emit           = 1'b1;
				close_end      = locus_pos_q;
				locus_pos_d    = '0;
				contig_start_d = '0;
				contig_bases_d = '0;
				kept_d         = '0;
				ins_open_d     = 1'b0;
				ins_col_d      = '0;
			end
			FUNC_RSVD: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		if (emit && res_d.kind == KIND_BASE && item_s1.func == FUNC_END) begin
			res_d = '0;
		end
		// close record fields
		if (item_s1.func == FUNC_END || (item_s1.func == FUNC_LOCUS
				&& vote.loc_best < min_depth)) begin
			res_d.kind          = KIND_CLOSE;
			res_d.base          = '0;
			res_d.contig_number = kept_q;
			res_d.start_locus   = contig_start_q;
			res_d.end_locus     = close_end;
			res_d.contig_length = contig_bases_q;
			res_d.keep          = keep_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locus_pos_q    <= '0;
			contig_start_q <= '0;
			contig_bases_q <= '0;
			kept_q         <= '0;
			locus_depth_q  <= '0;
			ins_open_q     <= 1'b0;
			ins_col_q      <= '0;
		end else if (advance) begin
			locus_pos_q    <= locus_pos_d;
			contig_start_q <= contig_start_d;
			contig_bases_q <= contig_bases_d;
			kept_q         <= kept_d;
			locus_depth_q  <= locus_depth_d;
			ins_open_q     <= ins_open_d;
			ins_col_q      <= ins_col_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= emit;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ins_col_q <= InsColW'(INS_COLS))
		else $error("insertion column past limit");

	a_open_room: assert property (@(posedge clk) disable iff (!arst_n)
		ins_open_q |-> ins_col_q < InsColW'(INS_COLS))
		else $error("insertion open with no column left");

	a_end_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func == FUNC_END |=>
			locus_pos_q == '0 && contig_bases_q == '0 && kept_q == '0 && !ins_open_q)
		else $error("end of reference did not rewind state");

	a_base_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.kind == KIND_BASE |->
			result_q.contig_length == '0 && !result_q.keep && result_q.end_locus == '0)
		else $error("base result carries close fields");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |-> !advance)
		else $error("stage 1 advanced over a waiting result");
`endif

endmodule

// ===== sv/pileup_consensus_contig_caller_unit.sv =====
// Top level of the pileup consensus contig caller: input register, config
// registers, vote logic and contig tracker. Depends on pcc_pkg, pcc_vote, pcc_track.
//
// The unit takes one pileup item per clock cycle when not stalled and turns
// it into at most one result: a consensus base, or a contig close record
// (start, end, length, keep) when a locus falls below min_depth or the
// reference ends. An accepted item is held in the input register, where the
// five-way majority compare and the contig counters are evaluated, and its
// result is then written to the result register, from which it is offered. Throughput
// is one item per cycle, set by the single compare-and-update step between the
// input and result registers; the input side stalls only while the result
// register holds a result that is not taken. Configuration writes are always
// accepted and should be issued only while no items are in flight.
module pileup_consensus_contig_caller_unit
	import pcc_pkg::*;
#(
	parameter int unsigned MAX_INSERT_COLUMNS = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [WordW-1:0] cfg_data
);

	logic              valid_s1;
	item_t             item_s1;
	logic              advance;
	vote_t             vote;
	logic [CountW-1:0] min_depth_q;
	logic [WordW-1:0]  min_length_q;

	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_depth_q  <= CountW'(1);
			min_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_DEPTH:  min_depth_q  <= cfg_data[CountW-1:0];
				REG_MIN_LENGTH: min_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pcc_vote u_vote (
		.item (item_s1),
		.vote (vote)
	);

	pcc_track #(
		.INS_COLS (MAX_INSERT_COLUMNS)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item_s1      (item_s1),
		.vote         (vote),
		.min_depth    (min_depth_q),
		.min_length   (min_length_q),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
